// ===== design/bounded_array_list_unit_macros.svh =====
`ifndef BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH
`define BOUNDED_ARRAY_LIST_UNIT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define BAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bal_pkg.sv =====
package bal_pkg;

  localparam int DEPTH    = 64;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 7;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int TREE_FAN = 8;
  localparam int TREE_GROUPS = (DEPTH + TREE_FAN - 1) / TREE_FAN;

  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_DROP    = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_ERASE   = 3'd3,
    KIND_READ_AT = 3'd4,
    KIND_FIRST   = 3'd5,
    KIND_LAST    = 3'd6,
    KIND_CLEAR   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_APPEND
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TREE,
    ST_OUT
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [LEN_W-1:0]  wpos;
    logic [LEN_W-1:0]  rpos;
    logic              rd_en;
    logic [DATA_W-1:0] item;
  } cell_ctrl_t;

endpackage

// ===== design/bounded_array_list_unit.sv =====
// Ordered list of up to 64 signed 32-bit words with an entry count.
// Input channel: in_valid / in_stall carry in_kind, in_position and in_item;
// an item is taken at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall carry out_status, out_read_value,
// out_length and out_is_empty; one result per item, in order.
// The entries sit in a chain of cells, each holding one word; insert and
// erase move every later word by one cell in the execute cycle, and reads
// gather the addressed cell's word through a two-level registered OR tree.
// The item passes through the execute state and then the two tree stages;
// its result is valid in the output state. One item is in flight at a time,
// so a new item is taken only after the receiver has taken the result of the
// last one.
// in_stall is high while an item is in flight or its result waits.
// While out_stall is high the result holds steady and nothing new is taken.
// Reset (rst_n low, synchronous) empties the list and drops any item in
// flight; stored words are not cleared and are unreachable until written.
`include "bounded_array_list_unit_macros.svh"

module bounded_array_list_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_kind,
  input  logic [bal_pkg::LEN_W-1:0]   in_position,
  input  logic signed [31:0]          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_read_value,
  output logic [bal_pkg::LEN_W-1:0]   out_length,
  output logic                        out_is_empty
);
  import bal_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  kind_t             req_kind_r;
  logic [LEN_W-1:0]  req_pos_r;
  logic [DATA_W-1:0] req_item_r;
  logic [LEN_W-1:0]  count_r;
  logic [LEN_W-1:0]  count_nxt;
  status_t           status_r;
  status_t           status_nxt;
  logic [LEN_W-1:0]  length_r;
  logic              is_empty_r;
  logic              list_full;
  logic              list_empty;
  cell_ctrl_t        op_ctrl;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_q  [DEPTH];
  logic [DATA_W-1:0] cell_rd [DEPTH];
  logic [DATA_W-1:0] rd_value;
  logic              rd_hold;

  assign list_full  = (count_r >= LEN_W'(DEPTH));
  assign list_empty = (count_r == '0);

  // decode the held request against the current count
  always_comb begin
    status_nxt    = STAT_OK;
    count_nxt     = count_r;
    op_ctrl.op    = CELL_HOLD;
    op_ctrl.wpos  = req_pos_r;
    op_ctrl.rpos  = req_pos_r;
    op_ctrl.rd_en = 1'b0;
    op_ctrl.item  = req_item_r;
    unique case (req_kind_r)
      KIND_APPEND: begin
        if (list_full) begin
          status_nxt = STAT_FULL;
        end else begin
          op_ctrl.op   = CELL_APPEND;
          op_ctrl.wpos = count_r;
          count_nxt    = count_r + LEN_W'(1);
        end
      end
      KIND_DROP: begin
        if (list_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          count_nxt = count_r - LEN_W'(1);
        end
      end
      KIND_INSERT: begin
        if (req_pos_r > count_r) begin
          status_nxt = STAT_RANGE;
        end else if (list_full) begin
          status_nxt = STAT_FULL;
        end else begin
          op_ctrl.op = CELL_INSERT;
          count_nxt  = count_r + LEN_W'(1);
        end
      end
      KIND_ERASE: begin
        if (list_empty) begin
          status_nxt = STAT_EMPTY;
        end else if (req_pos_r >= count_r) begin
          status_nxt = STAT_RANGE;
        end else begin
          op_ctrl.op = CELL_ERASE;
          count_nxt  = count_r - LEN_W'(1);
        end
      end
      KIND_READ_AT: begin
        if (list_empty) begin
          status_nxt = STAT_EMPTY;
        end else if (req_pos_r >= count_r) begin
          status_nxt = STAT_RANGE;
        end else begin
          op_ctrl.rd_en = 1'b1;
        end
      end
      KIND_FIRST: begin
        if (list_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          op_ctrl.rd_en = 1'b1;
          op_ctrl.rpos  = '0;
        end
      end
      KIND_LAST: begin
        if (list_empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          op_ctrl.rd_en = 1'b1;
          op_ctrl.rpos  = count_r - LEN_W'(1);
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
    endcase
  end

  // the cells only see a command during the execute cycle
  always_comb begin
    ctrl = op_ctrl;
    if (state_r != ST_EXEC) begin
      ctrl.op    = CELL_HOLD;
      ctrl.rd_en = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_TREE;
      end
      ST_TREE: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_kind_r <= kind_t'(in_kind);
      req_pos_r  <= in_position;
      req_item_r <= in_item;
    end
    if (state_r == ST_EXEC) begin
      status_r   <= status_nxt;
      length_r   <= count_nxt;
      is_empty_r <= (count_nxt == '0);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_q;
    logic [DATA_W-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    bal_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (IDX_W'(i)),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i]),
      .rd       (cell_rd[i])
    );
  end

  assign rd_hold = (state_r == ST_OUT);

  bal_rd_tree u_rd_tree (
    .clk      (clk),
    .hold     (rd_hold),
    .rd       (cell_rd),
    .rd_value (rd_value)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_status     = status_r;
  assign out_read_value = rd_value;
  assign out_length     = length_r;
  assign out_is_empty   = is_empty_r;

  `BAL_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == ST_EXEC,
    "accepted item did not enter execute")
  `BAL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= LEN_W'(DEPTH),
    "entry count above capacity")
  `BAL_ASSERT_NOW(a_no_take_while_out, out_valid, in_stall,
    "input open while a result is pending")
  `BAL_ASSERT_NOW(a_empty_flag, out_valid, out_is_empty == (out_length == '0),
    "empty flag disagrees with length")

endmodule

// ===== design/bal_cell.sv =====
module bal_cell (
  input  logic                       clk,
  input  bal_pkg::cell_ctrl_t        ctrl,
  input  logic [bal_pkg::IDX_W-1:0]  cell_idx,
  input  logic [bal_pkg::DATA_W-1:0] left_q,
  input  logic [bal_pkg::DATA_W-1:0] right_q,
  output logic [bal_pkg::DATA_W-1:0] q,
  output logic [bal_pkg::DATA_W-1:0] rd
);
  import bal_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [LEN_W-1:0]  idx_ext;

  assign idx_ext = LEN_W'(cell_idx);

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (idx_ext == ctrl.wpos) begin
          data_nxt = ctrl.item;
        end else if (idx_ext > ctrl.wpos) begin
          data_nxt = left_q;
        end
      end
      CELL_ERASE: begin
        if (idx_ext >= ctrl.wpos) begin
          data_nxt = right_q;
        end
      end
      CELL_APPEND: begin
        if (idx_ext == ctrl.wpos) begin
          data_nxt = ctrl.item;
        end
      end
      CELL_HOLD: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q  = data_r;
  // only the addressed cell drives the read bus
  assign rd = (ctrl.rd_en && (idx_ext == ctrl.rpos)) ? data_r : '0;

endmodule

// ===== design/bal_rd_tree.sv =====
module bal_rd_tree (
  input  logic                       clk,
  input  logic                       hold,
  input  logic [bal_pkg::DATA_W-1:0] rd [bal_pkg::DEPTH],
  output logic [bal_pkg::DATA_W-1:0] rd_value
);
  import bal_pkg::*;

  logic [DATA_W-1:0] group_or [TREE_GROUPS];
  logic [DATA_W-1:0] stage1_r [TREE_GROUPS];
  logic [DATA_W-1:0] total_or;
  logic [DATA_W-1:0] rd_value_r;

  for (genvar g = 0; g < TREE_GROUPS; g++) begin : g_group
    always_comb begin
      group_or[g] = '0;
      for (int k = 0; k < TREE_FAN; k++) begin
        if (g * TREE_FAN + k < DEPTH) begin
          group_or[g] = group_or[g] | rd[g * TREE_FAN + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      stage1_r[g] <= group_or[g];
    end
  end

  always_comb begin
    total_or = '0;
    for (int g = 0; g < TREE_GROUPS; g++) begin
      total_or = total_or | stage1_r[g];
    end
  end

  // keep the gathered word while the result waits
  always_ff @(posedge clk) begin
    if (!hold) begin
      rd_value_r <= total_or;
    end
  end

  assign rd_value = rd_value_r;

endmodule
